[rtl/pled_pkg.sv]
// Shared types and constants for the parallel LED bit waveform generator.
package pled_pkg;

   localparam int LANES     = 8;
   localparam int BUF_DEPTH = 4096;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);

   localparam int PERIOD_W  = 16;
   localparam int SLOT_W    = 13;
   localparam int GAP_W     = 8;
   localparam int ADDR_IN_W = 12;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   localparam logic [LANES-1:0] LANE_MASK = {LANES{1'b1}};
   localparam logic [GAP_W-1:0] GAP_MAX   = 8'hFF;

   localparam logic [PERIOD_W-1:0] SLOT_PERIOD_RST = 16'd300;
   localparam logic [PERIOD_W-1:0] DATA_OFFSET_RST = 16'd42;
   localparam logic [PERIOD_W-1:0] LOW_OFFSET_RST  = 16'd108;
   localparam logic [SLOT_W-1:0]   FRAME_SLOTS_RST = 13'd4096;
   localparam logic [GAP_W-1:0]    RESET_GAP_RST   = 8'd150;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_WRITE   = 2'd1,
      MODE_REQUEST = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_SLOT_PERIOD = 3'd0,
      REG_DATA_OFFSET = 3'd1,
      REG_LOW_OFFSET  = 3'd2,
      REG_FRAME_SLOTS = 3'd3,
      REG_RESET_GAP   = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] slot_period;
      logic [PERIOD_W-1:0] data_offset;
      logic [PERIOD_W-1:0] low_offset;
      logic [SLOT_W-1:0]   frame_slots;
      logic [GAP_W-1:0]    reset_gap;
   } cfg_type;

endpackage

[rtl/parallel_led_bit_waveform_gen.sv]
// Top level of the parallel LED bit waveform generator.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+----------------------------------
//   req     | in        | req_valid / req_ready | req_mode, req_slot_addr, req_lane_bits
//   rsp     | out       | rsp_valid / rsp_ready | rsp_pins, rsp_frame_done, rsp_sending
//   csr     | in/out    | psel, penable, pwrite | paddr, pwdata, prdata, pready
//
// A request beat is taken whenever the result register is empty or draining;
// its response is registered there, so the sustained rate is one beat per
// clock while rsp_ready stays high. The whole slot update is one pass of compare
// and increment logic between the stored state and the result register. The
// slice buffer is a RAM read ahead at the current slot index, with a one-entry
// bypass for a write that hits the same entry. Reset is synchronous, clears all
// control state but the slot index, which it sets to the frame length, and needs
// no clearing pass. A stalled response holds its register and no beat is taken.
module parallel_led_bit_waveform_gen (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [pled_pkg::ADDR_IN_W-1:0]  req_slot_addr,
   input  logic [pled_pkg::LANES-1:0]      req_lane_bits,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pled_pkg::LANES-1:0]      rsp_pins,
   output logic                            rsp_frame_done,
   output logic                            rsp_sending,
   // Configuration port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pled_pkg::CSR_AW-1:0]     paddr,
   input  logic [pled_pkg::CSR_DW-1:0]     pwdata,
   output logic [pled_pkg::CSR_DW-1:0]     prdata,
   output logic                            pready
);
   import pled_pkg::*;

   cfg_type cfg;

   // Waveform state.
   logic [PERIOD_W-1:0] tick_ff,    tick_in;
   logic [SLOT_W-1:0]   slot_ff,    slot_in;
   logic [GAP_W-1:0]    gap_ff,     gap_in;
   logic                stopped_ff, stopped_in;
   logic                pending_ff, pending_in;
   logic [LANES-1:0]    lines_ff,   lines_in;

   // Buffer read-ahead and bypass.
   logic               hit_ff, hit_in;
   logic [LANES-1:0]   byp_ff;
   logic [LANES-1:0]   ram_q;
   logic [LANES-1:0]   slice_q;
   logic               wr_en;
   logic [BUF_AW-1:0]  wr_addr;
   logic [BUF_AW-1:0]  rd_addr;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LANES-1:0]   rsp_pins_ff;
   logic               rsp_done_ff;
   logic               rsp_sending_ff;

   logic               accept;
   logic               done;
   logic               sending_now;
   logic [PERIOD_W:0]  tick_next;
   logic [GAP_W-1:0]   gap_inc;

   pled_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   assign pready = 1'b1;

   // A new beat is taken whenever the result register is empty or draining.
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   // The registered read always holds the entry at the current slot index;
   // a write in the previous cycle to that entry is supplied by the bypass.
   assign slice_q = hit_ff ? byp_ff : ram_q;
   assign wr_addr = BUF_AW'(req_slot_addr);
   assign rd_addr = BUF_AW'(slot_in);
   assign hit_in  = wr_en && (wr_addr == rd_addr);

   pled_ram #(
      .WIDTH (LANES),
      .DEPTH (BUF_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_lane_bits),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Slot update: the high, data and low points are applied in that order
   // when several of them fall on the same tick.
   always_comb begin
      tick_in     = tick_ff;
      slot_in     = slot_ff;
      gap_in      = gap_ff;
      stopped_in  = stopped_ff;
      pending_in  = pending_ff;
      lines_in    = lines_ff;
      done        = 1'b0;
      wr_en       = 1'b0;
      sending_now = slot_ff < cfg.frame_slots;
      tick_next   = {1'b0, tick_ff} + 17'd1;
      gap_inc     = (gap_ff == GAP_MAX) ? gap_ff : gap_ff + 8'd1;

      if (accept) begin
         case (mode_type'(req_mode))
            MODE_TICK: begin
               if ((tick_ff == '0) && sending_now) begin
                  lines_in = LANE_MASK;
               end
               if ((tick_ff == cfg.data_offset) && sending_now) begin
                  lines_in = slice_q;
                  slot_in  = slot_ff + 13'd1;
               end
               if (tick_ff == cfg.low_offset) begin
                  lines_in = '0;
                  // The frame is over: consume the request once, then count
                  // idle slots until a pending request may start a new frame.
                  if (slot_in >= cfg.frame_slots) begin
                     if (!stopped_ff) begin
                        pending_in = 1'b0;
                        stopped_in = 1'b1;
                        done       = 1'b1;
                     end
                     gap_in = gap_inc;
                     if ((gap_in > cfg.reset_gap) && pending_in) begin
                        stopped_in = 1'b0;
                        gap_in     = '0;
                        slot_in    = '0;
                     end
                  end
               end
               // The tick counter wraps when its next value reaches the slot period.
               tick_in = (tick_next >= {1'b0, cfg.slot_period}) ? '0
                                                                 : tick_next[PERIOD_W-1:0];
            end
            MODE_WRITE:   wr_en      = 1'b1;
            MODE_REQUEST: pending_in = 1'b1;
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         slot_ff      <= FRAME_SLOTS_RST;
         gap_ff       <= '0;
         stopped_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         lines_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         slot_ff      <= slot_in;
         gap_ff       <= gap_in;
         stopped_ff   <= stopped_in;
         pending_ff   <= pending_in;
         lines_ff     <= lines_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_ff <= req_lane_bits;
      if (accept) begin
         rsp_pins_ff    <= lines_in;
         rsp_done_ff    <= done;
         rsp_sending_ff <= slot_in < cfg.frame_slots;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pins       = rsp_pins_ff;
   assign rsp_frame_done = rsp_done_ff;
   assign rsp_sending    = rsp_sending_ff;

endmodule

[rtl/pled_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pled_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Read returns the contents from before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/pled_csr.sv]
// Configuration register file behind the APB-style port.
module pled_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pled_pkg::CSR_AW-1:0]   paddr,
   input  logic [pled_pkg::CSR_DW-1:0]   pwdata,
   output logic [pled_pkg::CSR_DW-1:0]   prdata,
   output pled_pkg::cfg_type             cfg
);
   import pled_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_stb;
   reg_idx_type idx;

   assign wr_stb = psel & penable & pwrite;
   assign idx    = reg_idx_type'(paddr[CSR_AW-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (idx)
            REG_SLOT_PERIOD: cfg_in.slot_period = pwdata[PERIOD_W-1:0];
            REG_DATA_OFFSET: cfg_in.data_offset = pwdata[PERIOD_W-1:0];
            REG_LOW_OFFSET:  cfg_in.low_offset  = pwdata[PERIOD_W-1:0];
            REG_FRAME_SLOTS: cfg_in.frame_slots = pwdata[SLOT_W-1:0];
            REG_RESET_GAP:   cfg_in.reset_gap   = pwdata[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SLOT_PERIOD: prdata = CSR_DW'(cfg_ff.slot_period);
         REG_DATA_OFFSET: prdata = CSR_DW'(cfg_ff.data_offset);
         REG_LOW_OFFSET:  prdata = CSR_DW'(cfg_ff.low_offset);
         REG_FRAME_SLOTS: prdata = CSR_DW'(cfg_ff.frame_slots);
         REG_RESET_GAP:   prdata = CSR_DW'(cfg_ff.reset_gap);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_period <= SLOT_PERIOD_RST;
         cfg_ff.data_offset <= DATA_OFFSET_RST;
         cfg_ff.low_offset  <= LOW_OFFSET_RST;
         cfg_ff.frame_slots <= FRAME_SLOTS_RST;
         cfg_ff.reset_gap   <= RESET_GAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
